@@ hdl/prm_pkg.sv @@
package prm_pkg;

    typedef struct packed {
        logic [11:0]        pixel_col;
        logic [11:0]        pixel_row;
        logic signed [31:0] disparity;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] proj_col;
        logic signed [31:0] proj_row;
        logic               in_front;
    } t_out_word;

    localparam logic [2:0] CFG_FOCAL_X     = 3'd0;
    localparam logic [2:0] CFG_FOCAL_Y     = 3'd1;
    localparam logic [2:0] CFG_CENTER_X    = 3'd2;
    localparam logic [2:0] CFG_CENTER_Y    = 3'd3;
    localparam logic [2:0] CFG_ROTATION    = 3'd4;
    localparam logic [2:0] CFG_TRANSLATION = 3'd5;

    localparam logic [31:0] RESET_FOCAL    = 32'h0001_0000;
    localparam logic [63:0] RESET_ROTATION = 64'h4000_0000_0000_0000;

    localparam logic signed [31:0] NEAR_RAW  = 32'sd655;
    localparam logic signed [31:0] FRONT_RAW = 32'sd16384;

endpackage

@@ hdl/pixel_reprojection_map.sv @@
// Reprojects a stream of pixels with disparity into a second camera view.
// The input channel takes one word per pixel (column, row, disparity) with
// i_valid and o_stall; the output channel gives one word per pixel
// (projected column, projected row, in-front flag) with o_valid and i_stall.
// A word is taken at a clock edge where valid is high and stall is low.
// The user writes camera intrinsics and the relative pose through the plain
// configuration port only while no pixel is in flight; it is not enforced.
// Every pixel produces exactly one result, in input order. One pixel is
// taken per clock when the output is not stalled.
// The pipeline holds two pipelined restoring dividers, two quotient bits
// per stage: 24 stages for the normalized ray and 32 for the projection.
// Reset empties the pipeline and loads unit focal lengths, a zero principal
// point, the identity rotation and zero translation.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_stall is raised in the same cycle; nothing is dropped or repeated.
module pixel_reprojection_map #(
    parameter int IMAGE_DIM = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  prm_pkg::t_in_word    i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output prm_pkg::t_out_word   o_data,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [63:0]          i_cfg_data
);

    localparam logic [16:0] DimLimit = 17'(IMAGE_DIM);
    localparam logic [16:0] DimLast  = 17'(IMAGE_DIM - 1);

    function automatic logic signed [31:0] f_sat(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    logic [31:0] r_fx, r_fy, r_cx, r_cy;
    logic [63:0] r_rot;
    logic [62:0] r_trans;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx    <= prm_pkg::RESET_FOCAL;
            r_fy    <= prm_pkg::RESET_FOCAL;
            r_cx    <= '0;
            r_cy    <= '0;
            r_rot   <= prm_pkg::RESET_ROTATION;
            r_trans <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                prm_pkg::CFG_FOCAL_X:     r_fx    <= i_cfg_data[31:0];
                prm_pkg::CFG_FOCAL_Y:     r_fy    <= i_cfg_data[31:0];
                prm_pkg::CFG_CENTER_X:    r_cx    <= i_cfg_data[31:0];
                prm_pkg::CFG_CENTER_Y:    r_cy    <= i_cfg_data[31:0];
                prm_pkg::CFG_ROTATION:    r_rot   <= i_cfg_data;
                prm_pkg::CFG_TRANSLATION: r_trans <= i_cfg_data[62:0];
                default: begin
                end
            endcase
        end
    end

    logic signed [15:0] q0, q1, q2, q3;
    logic signed [20:0] t0, t1, t2;
    logic [31:0]        den_x, den_y;

    assign q0 = r_rot[15:0];
    assign q1 = r_rot[31:16];
    assign q2 = r_rot[47:32];
    assign q3 = r_rot[63:48];
    assign t0 = r_trans[20:0];
    assign t1 = r_trans[41:21];
    assign t2 = r_trans[62:42];
    assign den_x = (r_fx == '0) ? 32'd1 : r_fx;
    assign den_y = (r_fy == '0) ? 32'd1 : r_fy;

    logic en;
    logic r_out_valid;

    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    // Stage 1: clamp the pixel coordinates.
    logic               r_v1;
    logic [11:0]        r_col1, r_row1;
    logic signed [31:0] r_w1;
    logic [11:0]        n_col1, n_row1;

    assign n_col1 = ({5'd0, i_data.pixel_col} >= DimLimit) ? DimLast[11:0] : i_data.pixel_col;
    assign n_row1 = ({5'd0, i_data.pixel_row} >= DimLimit) ? DimLast[11:0] : i_data.pixel_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_col1 <= n_col1;
            r_row1 <= n_row1;
            r_w1   <= i_data.disparity;
        end
    end

    // Stage 2: offset from the principal point, as sign and magnitude.
    logic               r_v2;
    logic [11:0]        r_col2, r_row2;
    logic signed [31:0] r_w2;
    logic [31:0]        r_magx, r_magy;
    logic               r_negx, r_negy;
    logic signed [33:0] diff_x, diff_y, abs_x, abs_y;

    assign diff_x = $signed({6'd0, r_col1, 16'd0}) - $signed({2'd0, r_cx});
    assign diff_y = $signed({6'd0, r_row1, 16'd0}) - $signed({2'd0, r_cy});
    assign abs_x  = diff_x[33] ? -diff_x : diff_x;
    assign abs_y  = diff_y[33] ? -diff_y : diff_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_col2 <= r_col1;
            r_row2 <= r_row1;
            r_w2   <= r_w1;
            r_magx <= abs_x[31:0];
            r_magy <= abs_y[31:0];
            r_negx <= diff_x[33];
            r_negy <= diff_y[33];
        end
    end

    // Ray division.
    localparam int RaySide = 1 + 12 + 12 + 32;

    logic               rdx_valid, rdy_valid;
    logic [47:0]        rdx_quo, rdy_quo;
    logic [RaySide-1:0] rdx_side;
    logic               rdy_side;

    prm_div #(.DW(48), .VW(32), .SW(RaySide), .BPS(2)) u_div_ray_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v2),
        .i_num   ({r_magx, 16'd0}),
        .i_den   (den_x),
        .i_side  ({r_negx, r_col2, r_row2, r_w2}),
        .o_valid (rdx_valid),
        .o_quo   (rdx_quo),
        .o_side  (rdx_side)
    );

    prm_div #(.DW(48), .VW(32), .SW(1), .BPS(2)) u_div_ray_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v2),
        .i_num   ({r_magy, 16'd0}),
        .i_den   (den_y),
        .i_side  (r_negy),
        .o_valid (rdy_valid),
        .o_quo   (rdy_quo),
        .o_side  (rdy_side)
    );

    // Stage 3: signed, saturated ray components.
    logic               r_v3;
    logic [11:0]        r_col3, r_row3;
    logic signed [31:0] r_w3, r_x0, r_x1;
    logic signed [65:0] ray_x, ray_y;

    assign ray_x = rdx_side[RaySide-1] ? -$signed({18'd0, rdx_quo}) : $signed({18'd0, rdx_quo});
    assign ray_y = rdy_side ? -$signed({18'd0, rdy_quo}) : $signed({18'd0, rdy_quo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= rdx_valid && rdy_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_col3 <= rdx_side[55:44];
            r_row3 <= rdx_side[43:32];
            r_w3   <= rdx_side[31:0];
            r_x0   <= f_sat(ray_x);
            r_x1   <= f_sat(ray_y);
        end
    end

    // Stage 4: cross product terms of the rotation and the translation scale.
    logic               r_v4;
    logic [11:0]        r_col4, r_row4;
    logic signed [31:0] r_x0_4, r_x1_4;
    logic signed [35:0] r_u0, r_u1, r_u2;
    logic signed [41:0] r_wt0, r_wt1, r_wt2;
    logic signed [47:0] p_q2x1, p_q0x1, p_q2x0, p_q1x0;
    logic signed [52:0] p_wt0, p_wt1, p_wt2;
    logic signed [39:0] n_u0, n_u1, n_u2;

    assign p_q2x1 = q2 * r_x1;
    assign p_q0x1 = q0 * r_x1;
    assign p_q2x0 = q2 * r_x0;
    assign p_q1x0 = q1 * r_x0;
    assign p_wt0  = r_w3 * t0;
    assign p_wt1  = r_w3 * t1;
    assign p_wt2  = r_w3 * t2;

    assign n_u0 = (40'(q1) * 40'sd8) - (40'(p_q2x1 >>> 14) <<< 1);
    assign n_u1 = (40'(p_q2x0 >>> 14) <<< 1) - (40'(q0) * 40'sd8);
    assign n_u2 = (40'(p_q0x1 >>> 14) - 40'(p_q1x0 >>> 14)) <<< 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_col4 <= r_col3;
            r_row4 <= r_row3;
            r_x0_4 <= r_x0;
            r_x1_4 <= r_x1;
            r_u0   <= n_u0[35:0];
            r_u1   <= n_u1[35:0];
            r_u2   <= n_u2[35:0];
            r_wt0  <= 42'(p_wt0 >>> 11);
            r_wt1  <= 42'(p_wt1 >>> 11);
            r_wt2  <= 42'(p_wt2 >>> 11);
        end
    end

    // Stage 5: second rotation products.
    logic               r_v5;
    logic [11:0]        r_col5, r_row5;
    logic signed [31:0] r_x0_5, r_x1_5;
    logic signed [41:0] r_wt0_5, r_wt1_5, r_wt2_5;
    logic signed [37:0] r_a0, r_b0, r_c0, r_a1, r_b1, r_c1, r_a2, r_b2, r_c2;
    logic signed [51:0] p_a0, p_b0, p_c0, p_a1, p_b1, p_c1, p_a2, p_b2, p_c2;

    assign p_a0 = q3 * r_u0;
    assign p_b0 = q1 * r_u2;
    assign p_c0 = q2 * r_u1;
    assign p_a1 = q3 * r_u1;
    assign p_b1 = q2 * r_u0;
    assign p_c1 = q0 * r_u2;
    assign p_a2 = q3 * r_u2;
    assign p_b2 = q0 * r_u1;
    assign p_c2 = q1 * r_u0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_col5  <= r_col4;
            r_row5  <= r_row4;
            r_x0_5  <= r_x0_4;
            r_x1_5  <= r_x1_4;
            r_wt0_5 <= r_wt0;
            r_wt1_5 <= r_wt1;
            r_wt2_5 <= r_wt2;
            r_a0    <= 38'(p_a0 >>> 14);
            r_b0    <= 38'(p_b0 >>> 14);
            r_c0    <= 38'(p_c0 >>> 14);
            r_a1    <= 38'(p_a1 >>> 14);
            r_b1    <= 38'(p_b1 >>> 14);
            r_c1    <= 38'(p_c1 >>> 14);
            r_a2    <= 38'(p_a2 >>> 14);
            r_b2    <= 38'(p_b2 >>> 14);
            r_c2    <= 38'(p_c2 >>> 14);
        end
    end

    // Stage 6: transformed point, saturated.
    logic               r_v6;
    logic [11:0]        r_col6, r_row6;
    logic signed [31:0] r_y0, r_y1, r_y2;
    logic signed [65:0] sum0, sum1, sum2;

    assign sum0 = 66'(r_x0_5) + 66'(r_a0) + (66'(r_b0) - 66'(r_c0)) + 66'(r_wt0_5);
    assign sum1 = 66'(r_x1_5) + 66'(r_a1) + (66'(r_b1) - 66'(r_c1)) + 66'(r_wt1_5);
    assign sum2 = 66'sd65536 + 66'(r_a2) + (66'(r_b2) - 66'(r_c2)) + 66'(r_wt2_5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_col6 <= r_col5;
            r_row6 <= r_row5;
            r_y0   <= f_sat(sum0);
            r_y1   <= f_sat(sum1);
            r_y2   <= f_sat(sum2);
        end
    end

    // Stage 7: scale by the focal lengths ahead of the depth division.
    logic               r_v7;
    logic [11:0]        r_col7, r_row7;
    logic [63:0]        r_prod0, r_prod1;
    logic [31:0]        r_z;
    logic               r_neg0, r_neg1, r_near, r_front;
    logic signed [32:0] abs0, abs1;
    logic               near;

    assign abs0 = r_y0[31] ? -33'(r_y0) : 33'(r_y0);
    assign abs1 = r_y1[31] ? -33'(r_y1) : 33'(r_y1);
    assign near = r_y2 > prm_pkg::NEAR_RAW;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else if (en) begin
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_col7  <= r_col6;
            r_row7  <= r_row6;
            r_prod0 <= abs0[31:0] * r_fx;
            r_prod1 <= abs1[31:0] * r_fy;
            r_z     <= near ? r_y2 : 32'd1;
            r_neg0  <= r_y0[31];
            r_neg1  <= r_y1[31];
            r_near  <= near;
            r_front <= r_y2 > prm_pkg::FRONT_RAW;
        end
    end

    // Depth division.
    localparam int PrjSide = 4 + 12 + 12;

    logic               pdx_valid, pdy_valid;
    logic [63:0]        pdx_quo, pdy_quo;
    logic [PrjSide-1:0] pdx_side;
    logic               pdy_side;

    prm_div #(.DW(64), .VW(32), .SW(PrjSide), .BPS(2)) u_div_prj_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v7),
        .i_num   (r_prod0),
        .i_den   (r_z),
        .i_side  ({r_neg0, r_neg1, r_near, r_front, r_col7, r_row7}),
        .o_valid (pdx_valid),
        .o_quo   (pdx_quo),
        .o_side  (pdx_side)
    );

    prm_div #(.DW(64), .VW(32), .SW(1), .BPS(2)) u_div_prj_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v7),
        .i_num   (r_prod1),
        .i_den   (r_z),
        .i_side  (r_neg1),
        .o_valid (pdy_valid),
        .o_quo   (pdy_quo),
        .o_side  (pdy_side)
    );

    // Output register.
    prm_pkg::t_out_word r_out;
    logic signed [65:0] prj_x, prj_y;
    logic [11:0]        out_col, out_row;

    assign out_col = pdx_side[23:12];
    assign out_row = pdx_side[11:0];
    assign prj_x = (pdx_side[27] ? -$signed({2'd0, pdx_quo}) : $signed({2'd0, pdx_quo}))
                   + $signed({34'd0, r_cx});
    assign prj_y = (pdy_side ? -$signed({2'd0, pdy_quo}) : $signed({2'd0, pdy_quo}))
                   + $signed({34'd0, r_cy});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= pdx_valid && pdy_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (pdx_side[25]) begin
                r_out.proj_col <= f_sat(prj_x);
                r_out.proj_row <= f_sat(prj_y);
            end else begin
                r_out.proj_col <= {4'd0, out_col, 16'd0};
                r_out.proj_row <= {4'd0, out_row, 16'd0};
            end
            r_out.in_front <= pdx_side[24];
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

@@ hdl/prm_div.sv @@
module prm_div #(
    parameter int DW  = 48,
    parameter int VW  = 32,
    parameter int SW  = 8,
    parameter int BPS = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_num,
    input  logic [VW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [DW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    localparam int NS = DW / BPS;

    logic [NS-1:0]                r_vld;
    logic [NS-1:0][DW-1:0]        r_num;
    logic [NS-1:0][VW:0]          r_rem;
    logic [NS-1:0][VW-1:0]        r_den;
    logic [NS-1:0][SW-1:0]        r_side;

    logic [NS-1:0][DW-1:0]        p_num;
    logic [NS-1:0][VW:0]          p_rem;
    logic [NS-1:0][VW-1:0]        p_den;
    logic [NS-1:0][SW-1:0]        p_side;
    logic [NS-1:0][DW-1:0]        n_num;
    logic [NS-1:0][VW:0]          n_rem;

    assign p_num  = {r_num[NS-2:0], i_num};
    assign p_rem  = {r_rem[NS-2:0], (VW+1)'(0)};
    assign p_den  = {r_den[NS-2:0], i_den};
    assign p_side = {r_side[NS-2:0], i_side};

    always_comb begin
        logic [VW:0]   rem;
        logic [DW-1:0] num;
        for (int s = 0; s < NS; s++) begin
            rem = p_rem[s];
            num = p_num[s];
            for (int k = 0; k < BPS; k++) begin
                rem = {rem[VW-1:0], num[DW-1]};
                num = {num[DW-2:0], 1'b0};
                if (rem >= {1'b0, p_den[s]}) begin
                    rem    = rem - {1'b0, p_den[s]};
                    num[0] = 1'b1;
                end
            end
            n_rem[s] = rem;
            n_num[s] = num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= n_num;
            r_rem  <= n_rem;
            r_den  <= p_den;
            r_side <= p_side;
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_quo   = r_num[NS-1];
    assign o_side  = r_side[NS-1];

endmodule
